[sv/msd_pkg.sv]
package msd_pkg;

    localparam int MAX_DIGITS = 8;
    localparam int DIGIT_W    = $clog2(MAX_DIGITS);
    localparam int COUNT_W    = 4;
    localparam int TICK_W     = 16;
    localparam int CODE_W     = 5;
    localparam int SEG_W      = 8;
    localparam int SEL_W      = 8;
    localparam int CFG_W      = 16;

    localparam logic [CODE_W-1:0]  INITIAL_CODE = 5'd16;
    localparam logic [CODE_W-1:0]  CODE_LIMIT   = 5'd17;
    localparam logic [COUNT_W-1:0] COUNT_RESET  = 4'd4;
    localparam logic [TICK_W-1:0]  STROBE_RESET = 16'd10;
    localparam logic [TICK_W-1:0]  TICK_MAX     = 16'hFFFF;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    localparam logic CFG_DIGIT_COUNT  = 1'b0;
    localparam logic CFG_STROBE_TICKS = 1'b1;

    typedef enum logic [1:0] {
        ST_INIT  = 2'd0,
        ST_IDLE  = 2'd1,
        ST_PRINT = 2'd2,
        ST_NEXT  = 2'd3
    } t_state;

    typedef struct packed {
        logic [SEL_W-1:0] selects;
        logic [SEG_W-1:0] segments;
    } t_pins;

    function automatic logic [SEG_W-1:0] seg_of(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] seg;
        unique case (code)
            5'd0:    seg = 8'h3F;
            5'd1:    seg = 8'h06;
            5'd2:    seg = 8'h5B;
            5'd3:    seg = 8'h4F;
            5'd4:    seg = 8'h66;
            5'd5:    seg = 8'h6D;
            5'd6:    seg = 8'h7D;
            5'd7:    seg = 8'h07;
            5'd8:    seg = 8'h7F;
            5'd9:    seg = 8'h6F;
            5'd10:   seg = 8'h77;
            5'd11:   seg = 8'h7C;
            5'd12:   seg = 8'h39;
            5'd13:   seg = 8'h5E;
            5'd14:   seg = 8'h79;
            5'd15:   seg = 8'h71;
            5'd17:   seg = 8'h1C;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

[sv/multiplexed_seven_segment_driver.sv]
// Multiplexed seven-segment display driver.
// The input stream carries one beat per event: tuser 0 is a time tick, tuser 1
// writes a digit code (tdata bits 2:0 digit index, bits 7:3 code). Every input
// beat yields exactly one output beat carrying the held segment levels, the held
// active-low digit selects and a flag that is set when a tick drove new levels.
// Codes 0 to 15 show hex digits, 16 is blank and 17 shows an error mark; other
// codes and writes to digits past the digit count are dropped.
// The configuration port sets the digit count and the ticks per digit; the user
// must write it only while the stream is idle, which the block does not enforce.
// An accepted input beat reaches the output register in the next cycle, and one
// beat is accepted in every cycle unless the receiver stalls; the output register
// is the only stage. When the receiver stalls, the output beat holds and the
// input side stops accepting until that beat is taken.
// After reset the state machine is in its init state, all digits hold the blank
// code, a print is pending, the segments are off and all selects are inactive.
module multiplexed_seven_segment_driver
    import msd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // digit_index[2:0], digit_code[7:3]
    input  logic               s_axis_tuser,   // cmd
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata,   // segment_lines[7:0], digit_select_lines[15:8]
    output logic               m_axis_tuser    // refreshed
);

    logic [COUNT_W-1:0]    r_digit_count;
    logic [TICK_W-1:0]     r_strobe_ticks;
    t_state                r_state, n_state;
    logic [CODE_W-1:0]     r_store [MAX_DIGITS];
    logic [CODE_W-1:0]     n_store [MAX_DIGITS];
    logic [DIGIT_W-1:0]    r_digit, n_digit;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic                  r_pending, n_pending;
    logic [SEG_W-1:0]      r_seg, n_seg;
    logic [SEL_W-1:0]      r_sel, n_sel;
    logic                  r_out_valid, n_out_valid;
    logic                  r_refreshed, n_refreshed;

    logic                  in_accept;
    logic [DIGIT_W-1:0]    in_index;
    logic [CODE_W-1:0]     in_code;
    logic [COUNT_W-1:0]    eff_count;
    logic [COUNT_W-1:0]    digit_inc;
    t_pins                 pins;

    assign in_index  = s_axis_tdata[DIGIT_W-1:0];
    assign in_code   = s_axis_tdata[DIGIT_W +: CODE_W];
    assign eff_count = (r_digit_count > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS)
                                                               : r_digit_count;
    assign digit_inc = COUNT_W'(r_digit) + COUNT_W'(1);

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    msd_pin_decode u_pin_decode (
        .i_code      (r_store[r_digit]),
        .i_digit     (r_digit),
        .i_eff_count (eff_count),
        .o_pins      (pins)
    );

    always_comb begin
        n_state     = r_state;
        n_store     = r_store;
        n_digit     = r_digit;
        n_tick      = r_tick;
        n_pending   = r_pending;
        n_seg       = r_seg;
        n_sel       = r_sel;
        n_refreshed = r_refreshed;
        n_out_valid = r_out_valid && !m_axis_tready;

        if (in_accept) begin
            n_out_valid = 1'b1;
            n_refreshed = 1'b0;
            if (s_axis_tuser == CMD_SET) begin
                if ((in_code <= CODE_LIMIT) && (COUNT_W'(in_index) < eff_count)) begin
                    n_store[in_index] = in_code;
                    n_pending         = 1'b1;
                end
            end else begin
                unique case (r_state)
                    ST_INIT: begin
                        n_state = ST_IDLE;
                    end
                    ST_IDLE: begin
                        if (r_pending) begin
                            n_state = ST_PRINT;
                        end else if (r_tick >= r_strobe_ticks) begin
                            n_state = ST_NEXT;
                        end
                    end
                    ST_PRINT: begin
                        n_pending = 1'b0;
                        n_state   = ST_IDLE;
                    end
                    ST_NEXT: begin
                        n_tick  = '0;
                        n_state = ST_PRINT;
                    end
                    default: begin
                        n_state = ST_INIT;
                    end
                endcase

                unique case (n_state)
                    ST_IDLE: begin
                        if (r_tick != TICK_MAX) begin
                            n_tick = r_tick + TICK_W'(1);
                        end
                    end
                    ST_PRINT: begin
                        n_seg       = pins.segments;
                        n_sel       = pins.selects;
                        n_refreshed = 1'b1;
                    end
                    ST_NEXT: begin
                        n_digit = (digit_inc >= eff_count) ? '0 : digit_inc[DIGIT_W-1:0];
                    end
                    default: begin
                        n_state = n_state;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count  <= COUNT_RESET;
            r_strobe_ticks <= STROBE_RESET;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_store[i] <= INITIAL_CODE;
            end
            r_digit     <= '0;
            r_tick      <= '0;
            r_pending   <= 1'b1;
            r_seg       <= '0;
            r_sel       <= '1;
            r_out_valid <= 1'b0;
            r_refreshed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DIGIT_COUNT:  r_digit_count  <= i_cfg_data[COUNT_W-1:0];
                    CFG_STROBE_TICKS: r_strobe_ticks <= i_cfg_data[TICK_W-1:0];
                    default:          r_digit_count  <= r_digit_count;
                endcase
            end
            r_store     <= n_store;
            r_digit     <= n_digit;
            r_tick      <= n_tick;
            r_pending   <= n_pending;
            r_seg       <= n_seg;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
            r_refreshed <= n_refreshed;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_sel, r_seg};
    assign m_axis_tuser  = r_refreshed;

`ifndef SYNTH
    a_refresh_in_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_refreshed) |-> (r_state == ST_PRINT))
        else $error("refreshed beat outside the print state");

    a_next_to_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (s_axis_tuser == CMD_TICK) && (r_state == ST_NEXT))
        |=> ((r_state == ST_PRINT) && (r_tick == '0) && r_refreshed))
        else $error("next-digit step did not clear the counter and print");

    a_set_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (s_axis_tuser == CMD_SET))
        |=> ($stable(r_state) && $stable(r_digit) && $stable(r_sel) && !r_refreshed))
        else $error("digit write disturbed the scan state");

    a_one_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(~r_sel))
        else $error("more than one digit select active");
`endif

endmodule

[sv/msd_pin_decode.sv]
module msd_pin_decode
    import msd_pkg::*;
(
    input  logic [CODE_W-1:0]  i_code,
    input  logic [DIGIT_W-1:0] i_digit,
    input  logic [COUNT_W-1:0] i_eff_count,
    output t_pins              o_pins
);

    always_comb begin
        o_pins.segments = seg_of(i_code);
        o_pins.selects  = '1;
        for (int i = 0; i < SEL_W; i++) begin
            if ((COUNT_W'(i) < i_eff_count) && (COUNT_W'(i) == COUNT_W'(i_digit))) begin
                o_pins.selects[i] = 1'b0;
            end
        end
    end

endmodule

[tb/tb_multiplexed_seven_segment_driver.sv]
`timescale 1ns / 1ps

module tb_multiplexed_seven_segment_driver;
    import msd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [SEL_W-1:0] sel;
        logic             refreshed;
    } t_lines;

    typedef struct packed {
        logic              cmd;
        logic [2:0]        idx;
        logic [CODE_W-1:0] code;
        bit                pinned;
        logic [SEG_W-1:0]  seg;
        logic [SEL_W-1:0]  sel;
        logic              refreshed;
    } t_row;

    localparam logic [SEG_W-1:0] GLYPHS [0:17] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71,
        8'h00, 8'h1C
    };

    // Rows with pinned set carry lines that follow directly from the reset state.
    t_row opening_rows [23] = '{
        '{CMD_TICK, 3'd0, 5'd0,  1'b1, 8'h00, 8'hFF, 1'b0},
        '{CMD_TICK, 3'd0, 5'd0,  1'b1, 8'h00, 8'hFE, 1'b1},
        '{CMD_SET,  3'd0, 5'd0,  1'b1, 8'h00, 8'hFE, 1'b0},
        '{CMD_TICK, 3'd5, 5'd31, 1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_SET,  3'd1, 5'd17, 1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_SET,  3'd2, 5'd31, 1'b1, 8'h00, 8'hFE, 1'b0},
        '{CMD_SET,  3'd3, 5'd15, 1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_SET,  3'd7, 5'd8,  1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_SET,  3'd0, 5'd18, 1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_TICK, 3'd7, 5'd16, 1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_TICK, 3'd2, 5'd1,  1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_TICK, 3'd4, 5'd2,  1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_TICK, 3'd1, 5'd4,  1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_TICK, 3'd0, 5'd8,  1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_TICK, 3'd6, 5'd31, 1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_TICK, 3'd3, 5'd0,  1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_TICK, 3'd0, 5'd0,  1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_TICK, 3'd0, 5'd0,  1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_TICK, 3'd0, 5'd0,  1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_TICK, 3'd0, 5'd0,  1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_TICK, 3'd0, 5'd0,  1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_TICK, 3'd0, 5'd0,  1'b0, 8'h00, 8'h00, 1'b0},
        '{CMD_TICK, 3'd0, 5'd0,  1'b0, 8'h00, 8'h00, 1'b0}
    };

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic               i_cfg_index   = CFG_DIGIT_COUNT;
    logic [CFG_W-1:0]   i_cfg_data    = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;   // digit_index[2:0], digit_code[7:3]
    logic               s_axis_tuser  = 1'b0; // cmd
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;         // segment_lines[7:0], digit_select_lines[15:8]
    logic               m_axis_tuser;         // refreshed

    logic [COUNT_W-1:0] model_count;
    logic [TICK_W-1:0]  model_strobe;
    t_state             model_state;
    logic [CODE_W-1:0]  digit_codes [MAX_DIGITS];
    int                 lit_digit;
    logic [TICK_W-1:0]  tick_run;
    bit                 redraw_due;
    logic [SEG_W-1:0]   seg_hold;
    logic [SEL_W-1:0]   sel_hold;

    t_lines lines_expected [$];
    int     mismatches = 0;
    int     cycles = 0;
    int     gap_odds = 6;
    bit     hold_off = 1'b0;

    multiplexed_seven_segment_driver DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_lines display_step(logic cmd, logic [2:0] idx,
                                            logic [CODE_W-1:0] code);
        t_lines            r;
        int                n;
        logic [CODE_W-1:0] shown;
        n = (model_count > MAX_DIGITS) ? MAX_DIGITS : int'(model_count);
        r.refreshed = 1'b0;
        if (cmd == CMD_SET) begin
            if (code <= CODE_LIMIT && idx < n) begin
                digit_codes[idx] = code;
                redraw_due = 1'b1;
            end
        end else begin
            case (model_state)
                ST_INIT: begin
                    model_state = ST_IDLE;
                end
                ST_IDLE: begin
                    if (redraw_due) begin
                        model_state = ST_PRINT;
                    end else if (tick_run >= model_strobe) begin
                        model_state = ST_NEXT;
                    end
                end
                ST_PRINT: begin
                    redraw_due = 1'b0;
                    model_state = ST_IDLE;
                end
                default: begin
                    tick_run = '0;
                    model_state = ST_PRINT;
                end
            endcase
            case (model_state)
                ST_IDLE: begin
                    if (tick_run != TICK_MAX) begin
                        tick_run++;
                    end
                end
                ST_PRINT: begin
                    shown = digit_codes[lit_digit];
                    seg_hold = (shown <= CODE_LIMIT) ? GLYPHS[shown] : '0;
                    sel_hold = '1;
                    if (lit_digit < n) begin
                        sel_hold[lit_digit] = 1'b0;
                    end
                    r.refreshed = 1'b1;
                end
                ST_NEXT: begin
                    lit_digit = (lit_digit + 1 >= n) ? 0 : lit_digit + 1;
                end
                default: begin
                end
            endcase
        end
        r.seg = seg_hold;
        r.sel = sel_hold;
        return r;
    endfunction

    task automatic send_beat(logic cmd, logic [2:0] idx, logic [CODE_W-1:0] code,
                             bit pinned, t_lines typed);
        t_lines predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {code, idx};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = display_step(cmd, idx, code);
        lines_expected.push_back(pinned ? typed : predicted);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(int count);
        int kind;
        repeat (count) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                send_beat(CMD_TICK, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                          1'b0, '0);
            end else if (kind < 92) begin
                send_beat(CMD_SET, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 17)),
                          1'b0, '0);
            end else begin
                send_beat(CMD_SET, 3'($urandom_range(0, 7)), 5'($urandom_range(18, 31)),
                          1'b0, '0);
            end
        end
    endtask

    task automatic program_reg(logic idx, logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (lines_expected.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_DIGIT_COUNT) begin
            model_count = value[COUNT_W-1:0];
        end else begin
            model_strobe = value;
        end
    endtask

    initial begin
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_lines want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (lines_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected output beat: segments %h selects %h refreshed %b",
                             m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser);
                end
            end else begin
                want = lines_expected.pop_front();
                if (m_axis_tdata[7:0] !== want.seg || m_axis_tdata[15:8] !== want.sel
                        || m_axis_tuser !== want.refreshed) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch at cycle %0d: segments %h/%h selects %h/%h %s",
                                 cycles, want.seg, m_axis_tdata[7:0], want.sel,
                                 m_axis_tdata[15:8],
                                 $sformatf("refreshed %b/%b (expected/actual)",
                                           want.refreshed, m_axis_tuser));
                    end
                end
            end
        end
    end

    initial begin
        t_lines typed;
        int     waited;
        model_count  = COUNT_RESET;
        model_strobe = STROBE_RESET;
        model_state  = ST_INIT;
        foreach (digit_codes[k]) begin
            digit_codes[k] = INITIAL_CODE;
        end
        lit_digit  = 0;
        tick_run   = '0;
        redraw_due = 1'b1;
        seg_hold   = '0;
        sel_hold   = '1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_rows[k]) begin
            typed = '{opening_rows[k].seg, opening_rows[k].sel, opening_rows[k].refreshed};
            send_beat(opening_rows[k].cmd, opening_rows[k].idx, opening_rows[k].code,
                      opening_rows[k].pinned, typed);
        end
        send_random(100);
        hold_off = 1'b1;
        send_random(200);

        gap_odds = 3;
        program_reg(CFG_DIGIT_COUNT, 16'd8);
        program_reg(CFG_STROBE_TICKS, 16'd0);
        send_random(250);

        gap_odds = 20;
        program_reg(CFG_DIGIT_COUNT, 16'd0);
        program_reg(CFG_STROBE_TICKS, 16'd1);
        send_random(150);

        gap_odds = 6;
        program_reg(CFG_DIGIT_COUNT, 16'd15);
        program_reg(CFG_STROBE_TICKS, 16'd2);
        send_random(250);

        program_reg(CFG_DIGIT_COUNT, 16'd3);
        program_reg(CFG_STROBE_TICKS, 16'd0);
        send_random(150);

        // With the longest strobe the scan stays on one digit while
        // interleaved writes force redraws.
        gap_odds = 0;
        program_reg(CFG_DIGIT_COUNT, 16'd2);
        program_reg(CFG_STROBE_TICKS, 16'hFFFF);
        repeat (20) begin
            send_beat(CMD_SET, 3'($urandom_range(0, 1)), 5'($urandom_range(0, 17)), 1'b0, '0);
            send_beat(CMD_TICK, 3'd0, 5'd0, 1'b0, '0);
            send_beat(CMD_TICK, 3'd0, 5'd0, 1'b0, '0);
        end
        repeat (12) begin
            send_beat(CMD_TICK, 3'd0, 5'd0, 1'b0, '0);
        end

        program_reg(CFG_DIGIT_COUNT, 16'd8);
        program_reg(CFG_STROBE_TICKS, 16'd4);
        send_random(250);

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (lines_expected.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && lines_expected.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/msd_pkg.sv
sv/msd_pin_decode.sv
sv/multiplexed_seven_segment_driver.sv
tb/tb_multiplexed_seven_segment_driver.sv
